FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define VAF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed (same cycle)");

// next-cycle implication, disabled while reset is low
`define VAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed (next cycle)");

`endif

FILE: hdl/vaf_pkg.sv
// ---------------------------------------------------------------------------
// vaf_pkg
// Types and constants of the volume adjust frame parser.
// ---------------------------------------------------------------------------
package vaf_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic signed [15:0] adjustment;
        logic               found;
        logic               bad_frame;
    } t_out;

    typedef enum logic [2:0] {
        PH_IDENT,
        PH_CHAN,
        PH_ADJ_HI,
        PH_ADJ_LO,
        PH_PEAKCNT,
        PH_PEAKSKIP
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  pending_high;
        logic [7:0]  pending_low;
        logic [5:0]  skip_cnt;
        logic        cand_match;
        logic [15:0] result_adj;
        logic        match_done;
    } t_parse_state;

    localparam logic [7:0]   REQ_CHAN_RST = 8'd1;
    localparam t_parse_state STATE_RST    = '{
        phase:        PH_IDENT,
        pending_high: 8'd0,
        pending_low:  8'd0,
        skip_cnt:     6'd0,
        cand_match:   1'b0,
        result_adj:   16'd0,
        match_done:   1'b0
    };

endpackage

FILE: hdl/vaf_parse_step.sv
// ---------------------------------------------------------------------------
// vaf_parse_step
// Per-byte parse step: next parse state and the frame result.
// ---------------------------------------------------------------------------
module vaf_parse_step
    import vaf_pkg::*;
(
    input  t_parse_state i_state,
    input  t_in          i_in,
    input  logic [7:0]   i_req_chan,
    output t_parse_state o_next,
    output t_out         o_result
);

    t_parse_state upd;
    t_phase       n_phase;
    logic [8:0]   peak_sum;
    logic [5:0]   peak_bytes;
    logic [5:0]   skip_dec;

    assign peak_sum   = {1'b0, i_in.data_byte} + 9'd7;
    assign peak_bytes = peak_sum[8:3];
    assign skip_dec   = i_state.skip_cnt - 6'd1;

    // next phase
    always_comb begin
        n_phase = i_state.phase;
        if (!i_state.match_done) begin
            case (i_state.phase)
                PH_IDENT: begin
                    if (i_in.data_byte == 8'd0) n_phase = PH_CHAN;
                end
                PH_ADJ_HI:  n_phase = PH_ADJ_LO;
                PH_ADJ_LO:  n_phase = PH_PEAKCNT;
                PH_PEAKCNT: begin
                    if (!i_state.cand_match) begin
                        n_phase = (peak_bytes == 6'd0) ? PH_CHAN : PH_PEAKSKIP;
                    end
                end
                PH_PEAKSKIP: begin
                    if (skip_dec == 6'd0) n_phase = PH_CHAN;
                end
                default: n_phase = PH_ADJ_HI;
            endcase
        end
    end

    // datapath fields
    always_comb begin
        upd       = i_state;
        upd.phase = n_phase;
        if (!i_state.match_done) begin
            case (i_state.phase)
                PH_ADJ_HI: upd.pending_high = i_in.data_byte;
                PH_ADJ_LO: upd.pending_low  = i_in.data_byte;
                PH_PEAKCNT: begin
                    if (i_state.cand_match) begin
                        upd.result_adj = {i_state.pending_high, i_state.pending_low};
                        upd.match_done = 1'b1;
                    end else begin
                        upd.skip_cnt = peak_bytes;
                    end
                end
                PH_PEAKSKIP: upd.skip_cnt = skip_dec;
                PH_IDENT:    ;
                default:     upd.cand_match = (i_in.data_byte == i_req_chan);
            endcase
        end
    end

    always_comb begin
        o_result.adjustment = upd.match_done ? signed'(upd.result_adj) : 16'sd0;
        o_result.found      = upd.match_done;
        o_result.bad_frame  = (upd.phase == PH_IDENT) && !upd.match_done;
        o_next              = i_in.last_byte ? STATE_RST : upd;
    end

endmodule

FILE: hdl/volume_adjust_frame_parser.sv
// ---------------------------------------------------------------------------
// volume_adjust_frame_parser
// Relative volume adjust frame body parser, one byte per transfer.
// ---------------------------------------------------------------------------
// Takes one frame body byte per cycle; the parse state advances in the same
// cycle the byte is taken. The byte marked last yields one result, registered
// in the output register, and the next byte starts a new frame. The
// input stalls only while a result is held by a stalled output.
module volume_adjust_frame_parser
    import vaf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out       o_out_data,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data
);

    t_parse_state r_state;
    t_parse_state n_state;
    t_out         n_result;
    t_out         r_out_data;
    logic         r_out_valid;
    logic [7:0]   r_req_chan;
    logic         in_xfer;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    vaf_parse_step u_step (
        .i_state    (r_state),
        .i_in       (i_in_data),
        .i_req_chan (r_req_chan),
        .o_next     (n_state),
        .o_result   (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RST;
            r_out_valid <= 1'b0;
            r_req_chan  <= REQ_CHAN_RST;
        end else begin
            if (i_cfg_wr_en) r_req_chan <= i_cfg_wr_data;
            if (in_xfer) r_state <= n_state;
            if (in_xfer && i_in_data.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in_data.last_byte) r_out_data <= n_result;
    end

endmodule

FILE: hdl/vaf_checker.sv
// ---------------------------------------------------------------------------
// vaf_checker
// Port-level checks of the volume adjust frame parser.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vaf_checker
    import vaf_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input t_in        i_in_data,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input t_out       o_out_data
);

    logic found_and_bad;
    logic out_no_match;
    logic adj_zero;
    logic last_xfer;
    logic out_held;

    assign found_and_bad = o_out_data.found && o_out_data.bad_frame;
    assign out_no_match  = o_out_valid && !o_out_data.found;
    assign adj_zero      = (o_out_data.adjustment == 16'sd0);
    assign last_xfer     = i_in_valid && !o_in_stall && i_in_data.last_byte;
    assign out_held      = o_out_valid && i_out_stall;

    `VAF_ASSERT_NOW(a_found_not_bad, i_clk, i_rst_n, o_out_valid, !found_and_bad)
    `VAF_ASSERT_NOW(a_no_match_zero, i_clk, i_rst_n, out_no_match, adj_zero)
    `VAF_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, last_xfer, o_out_valid)
    `VAF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(o_out_data))

endmodule

bind volume_adjust_frame_parser vaf_checker u_vaf_checker (.*);
